/* hw/rtl/lpo_pkg.sv */
// Package for the line position offset block: widths, fixed constants,
// register indexes and the controller state type. No dependencies.
`default_nettype none

package lpo_pkg;

  localparam int ReadW  = 10;
  localparam int QuotW  = 9;
  localparam int CntW   = 4;
  localparam int ProdW  = ReadW + QuotW;
  localparam int OffW   = 11;
  localparam int CfgIdxW = 3;

  localparam logic [QuotW-1:0] NormMax    = 9'd500;
  localparam logic [QuotW-1:0] NearWhite  = 9'd450;
  localparam logic [OffW-1:0]  LostOffset = 11'd1000;
  localparam logic [CntW-1:0]  DivSteps   = 4'd9;

  localparam logic [CfgIdxW-1:0] CfgWhiteLeft  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgWhiteRight = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgBlackLeft  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgBlackRight = 3'd3;

  typedef enum logic {
    StIdle,
    StBusy
  } lpo_state_e;

endpackage

`default_nettype wire

/* hw/rtl/lpo_norm.sv */
// One sensor lane: maps a reading onto 0..500 from its black and white levels
// with a bit-serial restoring divider. Depends on lpo_pkg.
`default_nettype none

module lpo_norm (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [lpo_pkg::ReadW-1:0] reading_i,
  input  wire logic [lpo_pkg::ReadW-1:0] black_i,
  input  wire logic [lpo_pkg::ReadW-1:0] white_i,
  output logic                           done_o,
  output logic [lpo_pkg::QuotW-1:0]      value_o
);
  import lpo_pkg::*;

  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [ReadW-1:0] rem_q, rem_d;
  logic [QuotW-1:0] sh_q, sh_d;
  logic [ReadW-1:0] div_q, div_d;

  logic             pos, neg;
  logic [ReadW-1:0] mag_a, mag_b;
  logic [ProdW-1:0] prod;
  logic [ReadW+1:0] trial;
  logic             ge;

  always_comb begin
    pos   = (reading_i > black_i) && (white_i > black_i);
    neg   = (reading_i < black_i) && (white_i < black_i);
    mag_a = pos ? (reading_i - black_i) : (black_i - reading_i);
    mag_b = pos ? (white_i - black_i) : (black_i - white_i);
    prod  = ProdW'(mag_a) * ProdW'(NormMax);
    trial = {1'b0, rem_q, sh_q[QuotW-1]} - {2'b00, div_q};
    ge    = !trial[ReadW+1];
  end

  always_comb begin
    cnt_d = cnt_q;
    rem_d = rem_q;
    sh_d  = sh_q;
    div_d = div_q;
    if (start_i) begin
      div_d = mag_b;
      rem_d = prod[ProdW-1:QuotW];
      if (!pos && !neg) begin
        sh_d  = '0;
        cnt_d = '0;
      end else if (mag_a >= mag_b) begin
        sh_d  = NormMax;
        cnt_d = '0;
      end else begin
        sh_d  = prod[QuotW-1:0];
        cnt_d = DivSteps;
      end
    end else if (cnt_q != '0) begin
      rem_d = ge ? trial[ReadW-1:0] : {rem_q[ReadW-2:0], sh_q[QuotW-1]};
      sh_d  = {sh_q[QuotW-2:0], ge};
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    sh_q  <= sh_d;
    div_q <= div_d;
  end

  assign done_o  = (cnt_q == '0);
  assign value_o = sh_q;

  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != '0) |-> (rem_q < div_q))
    else $error("divider remainder not below divisor");

  a_start_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> (cnt_q == DivSteps) || (cnt_q == '0))
    else $error("divider step count not loaded on start");

  a_value_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(cnt_q != '0) |-> (sh_q < NormMax))
    else $error("quotient out of range");

endmodule

`default_nettype wire

/* hw/rtl/lpo_decide.sv */
// Offset selection from the two normalized values, holding the last offset
// to pick the side when the line is lost. Depends on lpo_pkg.
`default_nettype none

module lpo_decide (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      commit_i,
  input  wire logic [lpo_pkg::QuotW-1:0] left_i,
  input  wire logic [lpo_pkg::QuotW-1:0] right_i,
  output logic signed [lpo_pkg::OffW-1:0] offset_o
);
  import lpo_pkg::*;

  logic signed [OffW-1:0] prev_q;
  logic signed [OffW-1:0] sum, diff;
  logic                   l_hi, l_lo, r_hi, r_lo, prev_pos, prev_neg;

  always_comb begin
    l_hi     = left_i > NearWhite;
    l_lo     = left_i < NearWhite;
    r_hi     = right_i > NearWhite;
    r_lo     = right_i < NearWhite;
    prev_neg = prev_q[OffW-1];
    prev_pos = !prev_q[OffW-1] && (prev_q != '0);
    sum      = $signed(OffW'(left_i) + OffW'(right_i));
    diff     = $signed(OffW'(right_i) - OffW'(left_i));
    if (l_hi && r_lo) begin
      offset_o = -sum;
    end else if (l_lo && r_hi) begin
      offset_o = sum;
    end else if (l_hi && r_hi && prev_pos) begin
      offset_o = $signed(LostOffset);
    end else if (l_hi && r_hi && prev_neg) begin
      offset_o = -$signed(LostOffset);
    end else begin
      offset_o = diff;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
    end else if (commit_i) begin
      prev_q <= offset_o;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/line_position_offset_core.sv */
// Top level of the line position offset block: configuration registers,
// request control, two sensor lanes and the output register.
// Depends on lpo_pkg, lpo_norm and lpo_decide.
//
// Each request carries a left and right reading; both lanes normalize in
// parallel with a nine-step bit-serial restoring divider, which a lane skips
// for equal or saturating levels. A new request is accepted once both lanes
// are done and the output register can take the result. The result
// sits in an output register and the next request is accepted while it waits.
`default_nettype none

module line_position_offset_core (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [lpo_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [lpo_pkg::ReadW-1:0]   cfg_data_i,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [lpo_pkg::ReadW-1:0]   left_reading_i,
  input  wire logic [lpo_pkg::ReadW-1:0]   right_reading_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic signed [lpo_pkg::OffW-1:0]  line_offset_o
);
  import lpo_pkg::*;

  logic [ReadW-1:0] white_left_q, white_right_q, black_left_q, black_right_q;

  lpo_state_e             state_q, state_d;
  logic                   start, commit, slot_free;
  logic                   l_done, r_done;
  logic [QuotW-1:0]       l_val, r_val;
  logic signed [OffW-1:0] offset;
  logic                   out_valid_q;
  logic signed [OffW-1:0] out_offset_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      white_left_q  <= '1;
      white_right_q <= '1;
      black_left_q  <= '0;
      black_right_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgWhiteLeft:  white_left_q  <= cfg_data_i;
        CfgWhiteRight: white_right_q <= cfg_data_i;
        CfgBlackLeft:  black_left_q  <= cfg_data_i;
        CfgBlackRight: black_right_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (in_valid_i) state_d = StBusy;
      StBusy: if (l_done && r_done && slot_free) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    commit     = 1'b0;
    unique case (state_q)
      StIdle: in_ready_o = 1'b1;
      StBusy: commit = l_done && r_done && slot_free;
      default: ;
    endcase
    start = in_ready_o && in_valid_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  lpo_norm u_norm_left (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .reading_i (left_reading_i),
    .black_i   (black_left_q),
    .white_i   (white_left_q),
    .done_o    (l_done),
    .value_o   (l_val)
  );

  lpo_norm u_norm_right (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .reading_i (right_reading_i),
    .black_i   (black_right_q),
    .white_i   (white_right_q),
    .done_o    (r_done),
    .value_o   (r_val)
  );

  lpo_decide u_decide (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .commit_i (commit),
    .left_i   (l_val),
    .right_i  (r_val),
    .offset_o (offset)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      out_offset_q <= offset;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign line_offset_o = out_offset_q;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == StBusy))
    else $error("request accepted without starting the lanes");

  a_idle_lanes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (l_done && r_done))
    else $error("ready while a lane is still dividing");

  a_offset_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((line_offset_o >= -11'sd1000) && (line_offset_o <= 11'sd1000)))
    else $error("offset out of range");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |-> (!out_valid_q || out_ready_i))
    else $error("result written over a waiting result");

endmodule

`default_nettype wire

/* test/tb.sv */
// Self-checking testbench for line_position_offset_core: random and directed reading pairs
// under several calibration settings, with a built-in offset predictor and a result scoreboard.
// Depends on lpo_pkg and line_position_offset_core.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lpo_pkg::*;

  localparam int ReadMax = (1 << ReadW) - 1;
  localparam int NumRegs = int'(CfgBlackRight) + 1;
  localparam int NumPhases = 8;
  localparam int PairsPerPhase = 90;
  localparam int SettleCycles = 16;
  localparam int IdleLimit = 1000;
  localparam int MaxPrinted = 20;

  typedef struct packed {
    logic [ReadW-1:0] left;
    logic [ReadW-1:0] right;
  } reading_pair_t;

  typedef struct packed {
    logic [ReadW-1:0]        left;
    logic [ReadW-1:0]        right;
    logic signed [OffW-1:0]  offset;
  } offset_check_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       cfg_we = 1'b0;
  logic [CfgIdxW-1:0]         cfg_index = '0;
  logic [ReadW-1:0]           cfg_data = '0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [ReadW-1:0]           left_rd = '0;
  logic [ReadW-1:0]           right_rd = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [OffW-1:0]     line_offset;

  reading_pair_t              reading_q[$];
  offset_check_t              offset_q[$];
  reading_pair_t              next_pair;
  offset_check_t              want;
  offset_check_t              got;
  logic [ReadW-1:0]           cal_level [NumRegs];
  logic signed [OffW-1:0]     last_offset = '0;
  int                         err_cnt = 0;
  int                         burst_left = 0;
  int                         gap_left = 0;
  int                         idle_cycles = 0;
  int                         mask_age = 0;
  logic [15:0]                ready_mask = '1;
  logic [3:0]                 mask_pos = '0;

  line_position_offset_core i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .left_reading_i (left_rd),
    .right_reading_i(right_rd),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .line_offset_o  (line_offset)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(string msg);
    if (err_cnt < MaxPrinted) begin
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    end
    err_cnt++;
  endtask

  function automatic int scale_reading(logic [ReadW-1:0] rd, logic [ReadW-1:0] blk,
                                       logic [ReadW-1:0] wht);
    int num;
    int den;
    int v;
    num = (int'(rd) - int'(blk)) * int'(NormMax);
    den = int'(wht) - int'(blk);
    if (den == 0) begin
      return 0;
    end
    v = num / den;
    if (v < 0) begin
      v = 0;
    end
    if (v > int'(NormMax)) begin
      v = int'(NormMax);
    end
    return v;
  endfunction

  function automatic logic signed [OffW-1:0] predict_offset(logic [ReadW-1:0] l_rd,
                                                            logic [ReadW-1:0] r_rd);
    int l_norm;
    int r_norm;
    int near;
    int lost;
    int d;
    l_norm = scale_reading(l_rd, cal_level[CfgBlackLeft], cal_level[CfgWhiteLeft]);
    r_norm = scale_reading(r_rd, cal_level[CfgBlackRight], cal_level[CfgWhiteRight]);
    near = int'(NearWhite);
    lost = int'(LostOffset);
    d = r_norm - l_norm;
    if (l_norm > near && r_norm < near) begin
      d = -(l_norm + r_norm);
    end else if (l_norm < near && r_norm > near) begin
      d = l_norm + r_norm;
    end else if (l_norm > near && r_norm > near && last_offset > 0) begin
      d = lost;
    end else if (l_norm > near && r_norm > near && last_offset < 0) begin
      d = -lost;
    end
    last_offset = d[OffW-1:0];
    return last_offset;
  endfunction

  function automatic logic [ReadW-1:0] pick_reading(logic [ReadW-1:0] blk,
                                                    logic [ReadW-1:0] wht);
    int span;
    int r;
    span = int'(wht) - int'(blk);
    case ($urandom_range(0, 3))
      0: begin
        r = int'($urandom_range(0, ReadMax));
      end
      1: begin
        r = int'(blk) + span * int'($urandom_range(0, 100)) / 100;
      end
      2: begin
        r = int'(blk) + span * 9 / 10 + int'($urandom_range(0, 8)) - 4;
      end
      default: begin
        r = int'(wht) + int'($urandom_range(0, 6)) - 3;
      end
    endcase
    if (r < 0) begin
      r = 0;
    end
    if (r > ReadMax) begin
      r = ReadMax;
    end
    return r[ReadW-1:0];
  endfunction

  task automatic queue_pair(int l_rd, int r_rd);
    reading_pair_t p;
    p.left = l_rd[ReadW-1:0];
    p.right = r_rd[ReadW-1:0];
    reading_q.push_back(p);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [ReadW-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx <= CfgBlackRight) begin
      cal_level[idx] = val;
    end
  endtask

  task automatic apply_levels(int wl, int wr, int bl, int br);
    logic [CfgIdxW-1:0] spare_idx;
    spare_idx = CfgIdxW'($urandom_range(int'(CfgBlackRight) + 1, (1 << CfgIdxW) - 1));
    write_reg(CfgWhiteLeft, wl[ReadW-1:0]);
    write_reg(CfgWhiteRight, wr[ReadW-1:0]);
    write_reg(CfgBlackLeft, bl[ReadW-1:0]);
    write_reg(CfgBlackRight, br[ReadW-1:0]);
    write_reg(spare_idx, ReadW'($urandom_range(0, ReadMax)));
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (reading_q.size() != 0 || in_valid || offset_q.size() != 0) begin
      @(negedge clk);
    end
    repeat (SettleCycles) @(negedge clk);
  endtask

  // Request driver: bursts of random length separated by random gaps.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      left_rd <= '0;
      right_rd <= '0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (in_valid && in_ready) begin
        want.left = left_rd;
        want.right = right_rd;
        want.offset = predict_offset(left_rd, right_rd);
        offset_q.push_back(want);
      end
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          in_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (reading_q.size() != 0) begin
          next_pair = reading_q.pop_front();
          in_valid <= 1'b1;
          left_rd <= next_pair.left;
          right_rd <= next_pair.right;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with a rotating ready pattern, replaced by a new random choice when its age counter runs out.
  always @(posedge clk) begin
    if (out_valid && out_ready) begin
      if (offset_q.size() == 0) begin
        report_mismatch($sformatf("result %0d with no request pending", line_offset));
      end else begin
        got = offset_q.pop_front();
        if (line_offset !== got.offset) begin
          report_mismatch($sformatf("left %0d right %0d: line_offset %0d, expected %0d",
                                    got.left, got.right, line_offset, got.offset));
        end
      end
    end
    if (mask_age == 0) begin
      mask_age <= 99;
      case ($urandom_range(0, 3))
        0: ready_mask <= '1;
        1: ready_mask <= 16'($urandom);
        2: ready_mask <= 16'h8000;
        default: ready_mask <= 16'hF0F0;
      endcase
    end else begin
      mask_age <= mask_age - 1;
    end
    out_ready <= rst_n && ready_mask[mask_pos];
    mask_pos <= mask_pos + 1'b1;
  end

  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int wl;
    int wr;
    int bl;
    int br;
    cal_level[CfgWhiteLeft] = ReadW'(ReadMax);
    cal_level[CfgWhiteRight] = ReadW'(ReadMax);
    cal_level[CfgBlackLeft] = '0;
    cal_level[CfgBlackRight] = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset calibration: threshold edges, lost-line sides and the zero-history case.
    queue_pair(0, 0);
    queue_pair(ReadMax, ReadMax);
    queue_pair(0, ReadMax);
    queue_pair(ReadMax, ReadMax);
    queue_pair(ReadMax, ReadMax);
    queue_pair(ReadMax, 0);
    queue_pair(ReadMax, ReadMax);
    queue_pair(921, 100);
    queue_pair(100, 921);
    queue_pair(921, 921);
    queue_pair(923, 920);
    queue_pair(920, 923);
    queue_pair(923, 923);
    queue_pair(ReadMax, 0);
    queue_pair(923, 923);
    queue_pair(1, 1);
    queue_pair(512, 256);
    queue_pair('h2AA, 'h155);
    queue_pair('h155, 'h2AA);
    queue_pair(ReadMax, 922);
    queue_pair(512, 512);
    queue_pair(923, 923);
    wait_drained();

    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0: apply_levels(ReadMax, ReadMax, 0, 0);
        1: apply_levels(512, 800, 512, 100);
        2: apply_levels(0, 200, ReadMax, 900);
        3: apply_levels(ReadMax, 0, ReadMax, 0);
        4: apply_levels(310, 700, 300, 650);
        default: begin
          wl = $urandom_range(0, ReadMax);
          wr = $urandom_range(0, ReadMax);
          bl = $urandom_range(0, ReadMax);
          br = $urandom_range(0, ReadMax);
          if ($urandom_range(0, 3) == 0) begin
            bl = wl;
          end
          apply_levels(wl, wr, bl, br);
        end
      endcase
      @(negedge clk);
      for (int n = 0; n < PairsPerPhase; n++) begin
        queue_pair(int'(pick_reading(cal_level[CfgBlackLeft], cal_level[CfgWhiteLeft])),
                   int'(pick_reading(cal_level[CfgBlackRight], cal_level[CfgWhiteRight])));
      end
      wait_drained();
    end

    if (offset_q.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", offset_q.size()));
    end
    if (err_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
